// File: design/assert_macros.svh
// Assertion macros shared by the calendar add-hours RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while in reset.
`define CAH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication check, disabled while in reset.
`define CAH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/cah_pkg.sv
// Types, constants and helper functions for the calendar add-hours unit.
package cah_pkg;

  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned HOUR_W      = 5;
  localparam int unsigned ADD_W       = 16;
  localparam int unsigned TOTAL_W     = 17;
  localparam int unsigned DAYS_W      = 12;
  localparam int unsigned REM100_W    = 7;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
  localparam logic [14:0]        DIV24_RECIP  = 15'd21846;  // ceil(2^16 / 3)
  localparam logic [12:0]        DIV100_RECIP = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [REM100_W-1:0] REM100_LAST = 7'd99;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0]  DAY_LAST  = 5'd31;
  localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_WALK,
    ST_PUSH
  } cah_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic rem;
    logic step;
    logic push;
  } cah_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } cah_status_t;

  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    unique case (m)
      MONTH_FEB:                               month_days = 5'd28 + {4'd0, leap};
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_days = 5'd30;
      default:                                 month_days = 5'd31;
    endcase
  endfunction

endpackage

// File: design/cah_ctrl.sv
// Sequencing state machine for the calendar add-hours unit.
`include "assert_macros.svh"

module cah_ctrl
  import cah_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cah_status_t status,
  output cah_cmd_t    cmd
);

  cah_state_t state;
  cah_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_REM;
      ST_REM:  state_next = ST_WALK;
      ST_WALK: begin
        if (status.walk_done) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_REM:  cmd.rem = 1'b1;
      ST_WALK: cmd.step = !status.walk_done;
      ST_PUSH: cmd.push = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `CAH_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.mul, cmd.rem, cmd.step, cmd.push}), "more than one datapath command")
  `CAH_ASSERT_IMPL(a_load_then_mul, cmd.load, cmd.mul, "multiply did not follow load")

endmodule

// File: design/cah_dp.sv
// Datapath for the calendar add-hours unit: hour split, month walk, result register.
`include "assert_macros.svh"

module cah_dp
  import cah_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cah_cmd_t               cmd,
  output cah_status_t            status,
  input  logic [IN_TDATA_W-1:0]  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_ovf
);

  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAYS_W-1:0]   day;
  logic [HOUR_W-1:0]   hour;
  logic [TOTAL_W-1:0]  total;
  logic [28:0]         q_prod;
  logic [26:0]         c_prod;
  logic [REM100_W-1:0] rem100;
  logic [1:0]          cent;
  logic                ovf;

  logic [YEAR_W-1:0]   in_year;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic [HOUR_W-1:0]   in_hour;
  logic [ADD_W-1:0]    in_add;

  logic [DAYS_W-1:0]   quot;
  logic [TOTAL_W-1:0]  hour_diff;
  logic [REM100_W-1:0] cent_full;
  logic [YEAR_W-1:0]   year_diff;
  logic                leap;
  logic [DAY_W-1:0]    mdays;

  assign in_year  = in_data[13:0];
  assign in_month = in_data[17:14];
  assign in_day   = in_data[22:18];
  assign in_hour  = in_data[27:23];
  assign in_add   = in_data[43:28];

  // total / 24 = (total / 8) / 3, exact for the input range
  assign quot      = q_prod[27:16];
  assign hour_diff = total - ({1'b0, quot, 4'd0} + {2'b0, quot, 3'd0});
  assign cent_full = c_prod[25:19];
  assign year_diff = year - ({1'b0, cent_full, 6'd0} + {2'b0, cent_full, 5'd0}
                             + {5'd0, cent_full, 2'd0});

  assign leap   = (rem100 == '0) ? (cent == 2'd0) : (year[1:0] == 2'd0);
  assign mdays  = month_days(month, leap);

  assign status.walk_done = ovf || (day <= {{(DAYS_W-DAY_W){1'b0}}, mdays});
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= in_year;
      month <= (in_month == '0) ? MONTH_JAN : ((in_month > MONTH_DEC) ? MONTH_DEC : in_month);
      day   <= {{(DAYS_W-DAY_W){1'b0}}, (in_day == '0) ? 5'd1 : in_day};
      total <= {{(TOTAL_W-HOUR_W){1'b0}}, in_hour} + {1'b0, in_add};
    end
    if (cmd.mul) begin
      q_prod <= total[16:3] * DIV24_RECIP;
      c_prod <= year * DIV100_RECIP;
    end
    if (cmd.rem) begin
      hour   <= hour_diff[HOUR_W-1:0];
      day    <= day + quot;
      rem100 <= year_diff[REM100_W-1:0];
      cent   <= cent_full[1:0];
      ovf    <= year > YEAR_MAX;
    end
    if (cmd.step) begin
      day <= day - {{(DAYS_W-DAY_W){1'b0}}, mdays};
      if (month == MONTH_DEC) begin
        month <= MONTH_JAN;
        if (year == YEAR_MAX) begin
          ovf <= 1'b1;
        end else begin
          year <= year + 14'd1;
          if (rem100 == REM100_LAST) begin
            rem100 <= '0;
            cent   <= cent + 2'd1;
          end else begin
            rem100 <= rem100 + 7'd1;
          end
        end
      end else begin
        month <= month + 4'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_ovf <= ovf;
      if (ovf) begin
        out_data <= {4'd0, HOUR_LAST, DAY_LAST, MONTH_DEC, YEAR_MAX};
      end else begin
        out_data <= {4'd0, hour, day[DAY_W-1:0], month, year};
      end
    end
  end

  `CAH_ASSERT_IMPL(a_push_valid, cmd.push, out_valid, "pushed result not presented")
  `CAH_ASSERT_IMPL(a_hour_range, cmd.rem, hour <= HOUR_LAST, "hour out of range after split")
  `CAH_ASSERT(a_step_needed, cmd.step |-> (!ovf && day > {{(DAYS_W-DAY_W){1'b0}}, mdays}), "month step with day in range")
  `CAH_ASSERT(a_ovf_saturated, (out_valid && out_ovf) |-> (out_data[13:0] == YEAR_MAX), "overflow result not saturated")

endmodule

// File: design/calendar_add_hours_unit.sv
// Calendar add-hours unit: advances a Gregorian date and hour by a count of hours.
// One request at a time. After a request is taken, the unit splits the hour sum
// into whole days and an hour of day (constant-reciprocal multiplies in the MUL
// and REM states), then walks forward one month per cycle until the day fits
// its month, then loads the result register. The month walk in the datapath
// sets how long a request takes, growing with the month boundaries crossed. A
// new request is taken while a finished result still waits in the output
// register. Start years above 9999, or a walk past 9999, give 9999-12-31 hour
// 23 with the overflow flag in tuser set.
module calendar_add_hours_unit
  import cah_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], start_hour[27:23],
  // hours_to_add[43:28], zero[47:44]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // new_year[13:0], new_month[17:14], new_day[22:18], new_hour[27:23], zero[31:28]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // year_overflow[0]
  output logic                   m_axis_tuser
);

  cah_cmd_t    cmd;
  cah_status_t status;

  cah_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cah_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_ovf   (m_axis_tuser)
  );

endmodule
